// ----- design/plnb_pkg.sv -----
// ----------------------------------------------------------------------------
// Pose blend package
// Widths, pipeline stage counts, word types and helpers shared by the
// pose lerp and nlerp blend core.
// ----------------------------------------------------------------------------
package plnb_pkg;

	// Component format: Q16.16 in 32 bits.
	localparam int CW = 32;
	localparam int FB = 16;

	// Configuration register widths and the APB address width.
	localparam int WW = FB + 1;
	localparam int TW = 16;
	localparam int AW = 3;
	localparam int DW = 32;

	// Squared length width: four terms of (2*CW-1-FB) bits.
	localparam int LW = 2 * CW - FB + 1;
	// Quotient of 2^(3*FB) by the squared length.
	localparam int QW = 3 * FB + 1;
	// Divider remainder stays below the squared length.
	localparam int RW = LW;
	// Square root: result bits, working width of the root register.
	localparam int SQ_STEPS = (QW + 1) / 2;
	localparam int SRW = QW + 1;
	localparam int IW = SQ_STEPS;

	// Pipeline layout.
	localparam int FRONT_ST = 9;
	localparam int DIV_PER = 2;
	localparam int DIV_ST = (QW + DIV_PER - 1) / DIV_PER;
	localparam int SQ_PER = 2;
	localparam int SQ_ST = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
	localparam int NPS = FRONT_ST + DIV_ST + SQ_ST + 1;

	// Register indexes on the configuration port.
	typedef enum logic {
		REG_BLEND_WEIGHT = 1'b0,
		REG_UNIT_TOL     = 1'b1
	} reg_ix_t;

	typedef logic signed [CW-1:0] comp_t;

	typedef struct packed {
		logic  mode;
		comp_t first_c0;
		comp_t first_c1;
		comp_t first_c2;
		comp_t first_c3;
		comp_t second_c0;
		comp_t second_c1;
		comp_t second_c2;
		comp_t second_c3;
	} in_word_t;

	typedef struct packed {
		comp_t blend_c0;
		comp_t blend_c1;
		comp_t blend_c2;
		comp_t blend_c3;
	} out_word_t;

	// Data that rides along with an item through the normalization stages.
	typedef struct packed {
		logic              mode;
		logic              skip;
		logic [3:0][CW-1:0] c;
	} side_t;

	// Saturate a wide signed value to one component.
	function automatic comp_t sat_c(input logic signed [63:0] x);
		logic signed [63:0] cmax;
		logic signed [63:0] cmin;
		cmax = $signed({{(64 - CW + 1){1'b0}}, {(CW - 1){1'b1}}});
		cmin = ~cmax;
		if (x > cmax) begin
			sat_c = cmax[CW-1:0];
		end else if (x < cmin) begin
			sat_c = cmin[CW-1:0];
		end else begin
			sat_c = x[CW-1:0];
		end
	endfunction

endpackage

// ----- design/pose_lerp_nlerp_blend_core.sv -----
// ----------------------------------------------------------------------------
// Pose lerp / nlerp blend core
// Blends one joint component group per word: vector lerp for position and
// scale, shortest-path normalized quaternion lerp for rotation.
// ----------------------------------------------------------------------------
// The core takes one word per cycle while it does not raise pose_stall,
// and returns one word for each, in order. The pipeline holds a 25-stage
// divider that forms two quotient bits per stage and a 13-stage square
// root that forms two root bits per stage, behind nine stages of lerp and
// squared-length logic and one multiply stage. Vector words go through
// the same stages. The weight and tolerance registers may be changed only
// while the core is empty. An output register and a one-word skid buffer
// let the core take one more word while a result waits.
module pose_lerp_nlerp_blend_core import plnb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [DW-1:0] pwdata,
	output logic [DW-1:0] prdata,
	output logic          pready,
	input  logic          pose_valid,
	output logic          pose_stall,
	input  in_word_t      pose,
	output logic          blend_valid,
	input  logic          blend_stall,
	output out_word_t     blend
);

	localparam logic [WW-1:0] ONE_W = {1'b1, {FB{1'b0}}};
	localparam int PW = CW + WW + 3;
	localparam int MW = CW + IW + 1;

	// Configuration registers.
	logic [WW-1:0] weight_q;
	logic [TW-1:0] tol_q;
	logic [WW-1:0] t_eff;
	reg_ix_t       cfg_ix;

	assign pready = 1'b1;
	assign cfg_ix = reg_ix_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
			tol_q    <= TW'(1);
		end else if (psel && penable && pwrite) begin
			case (cfg_ix)
				REG_BLEND_WEIGHT: weight_q <= pwdata[WW-1:0];
				REG_UNIT_TOL:     tol_q    <= pwdata[TW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_ix)
			REG_BLEND_WEIGHT: prdata = DW'(weight_q);
			REG_UNIT_TOL:     prdata = DW'(tol_q);
			default:          prdata = '0;
		endcase
	end

	// A weight above one acts as exactly one.
	assign t_eff = (weight_q > ONE_W) ? ONE_W : weight_q;

	// Pipeline advance: the whole pipeline moves unless the skid word is held.
	logic           skid_v_q;
	logic           en;
	logic [NPS-1:0] vld_s;

	assign en         = !skid_v_q;
	assign pose_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NPS-2:0], pose_valid};
		end
	end

	// Stage 1: input register.
	in_word_t in_s1;
	comp_t    a1 [4];
	comp_t    b1 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= pose;
		end
	end

	assign a1[0] = in_s1.first_c0;
	assign a1[1] = in_s1.first_c1;
	assign a1[2] = in_s1.first_c2;
	assign a1[3] = in_s1.first_c3;
	assign b1[0] = in_s1.second_c0;
	assign b1[1] = in_s1.second_c1;
	assign b1[2] = in_s1.second_c2;
	assign b1[3] = in_s1.second_c3;

	// Stage 2: products for the dot product.
	comp_t                   a_s2 [4];
	comp_t                   b_s2 [4];
	logic signed [2*CW-1:0]  prod_s2 [4];
	logic                    mode_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= a1[i] * b1[i];
			end
			a_s2    <= a1;
			b_s2    <= b1;
			mode_s2 <= in_s1.mode;
		end
	end

	// Stage 3: dot product sign picks the shorter arc.
	comp_t                  a_s3 [4];
	comp_t                  b_s3 [4];
	logic                   neg_s3;
	logic                   mode_s3;
	logic signed [2*CW+1:0] dot;

	always_comb begin
		dot = '0;
		for (int i = 0; i < 4; i++) begin
			dot = dot + $signed({{2{prod_s2[i][2*CW-1]}}, prod_s2[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			neg_s3  <= mode_s2 & dot[2*CW+1];
			mode_s3 <= mode_s2;
		end
	end

	// Stage 4: difference of the (possibly negated) second value and the first.
	comp_t                a_s4 [4];
	logic signed [CW+1:0] d_s4 [4];
	logic                 mode_s4;
	logic signed [CW:0]   bx [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bx[i] = $signed({b_s3[i][CW-1], b_s3[i]});
			if (neg_s3) begin
				bx[i] = -bx[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				d_s4[i] <= $signed({bx[i][CW], bx[i]}) -
					$signed({{2{a_s3[i][CW-1]}}, a_s3[i]});
			end
			a_s4    <= a_s3;
			mode_s4 <= mode_s3;
		end
	end

	// Stage 5: scale the difference by the weight.
	comp_t                a_s5 [4];
	logic signed [PW-1:0] p_s5 [4];
	logic                 mode_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				p_s5[i] <= d_s4[i] * $signed({1'b0, t_eff});
			end
			a_s5    <= a_s4;
			mode_s5 <= mode_s4;
		end
	end

	// Stage 6: round, add and saturate; vector mode forces component 3 to zero.
	comp_t                c_s6 [4];
	logic                 mode_s6;
	logic signed [PW-1:0] pr [4];
	logic signed [63:0]   ls [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pr[i] = p_s5[i] + $signed(PW'(1) << (FB - 1));
			ls[i] = $signed({{(64 - PW){pr[i][PW-1]}}, pr[i]}) >>> FB;
			ls[i] = ls[i] + $signed({{(64 - CW){a_s5[i][CW-1]}}, a_s5[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s6[i] <= sat_c(ls[i]);
			end
			c_s6[3] <= mode_s5 ? sat_c(ls[3]) : '0;
			mode_s6 <= mode_s5;
		end
	end

	// Stage 7: squares of the blended components.
	comp_t                  c_s7 [4];
	logic [2*CW-2-FB:0]     sq_s7 [4];
	logic                   mode_s7;
	logic signed [2*CW-1:0] sqf [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sqf[i] = c_s6[i] * c_s6[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s7[i] <= sqf[i][2*CW-2:FB];
			end
			c_s7    <= c_s6;
			mode_s7 <= mode_s6;
		end
	end

	// Stage 8: squared length.
	comp_t         c_s8 [4];
	logic [LW-1:0] len_s8;
	logic          mode_s8;
	logic [LW-1:0] len_sum;

	always_comb begin
		len_sum = '0;
		for (int i = 0; i < 4; i++) begin
			len_sum = len_sum + LW'(sq_s7[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8    <= c_s7;
			len_s8  <= len_sum;
			mode_s8 <= mode_s7;
		end
	end

	// Stage 9: decide whether normalization is skipped.
	side_t              side_s9;
	logic [LW-1:0]      len_s9;
	logic signed [LW:0] ld;
	logic [LW:0]        ad;
	logic               skip9;

	always_comb begin
		ld = $signed({1'b0, len_s8}) - $signed((LW + 1)'(ONE_W));
		ad = ld[LW] ? $unsigned(-ld) : $unsigned(ld);
		skip9 = !mode_s8 || (len_s8 == '0) ||
			(ad <= {{(LW + 1 - TW){1'b0}}, tol_q});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s9.mode <= mode_s8;
			side_s9.skip <= skip9;
			for (int i = 0; i < 4; i++) begin
				side_s9.c[i] <= c_s8[i];
			end
			len_s9 <= len_s8;
		end
	end

	// Divider stages: 2^(3*FB) / length, two restoring steps per stage.
	side_t         dv_side_s [DIV_ST];
	logic [LW-1:0] dv_len_s  [DIV_ST];
	logic [RW-1:0] dv_rem_s  [DIV_ST];
	logic [QW-1:0] dv_quo_s  [DIV_ST];
	side_t         dv_side_i [DIV_ST];
	logic [LW-1:0] dv_len_i  [DIV_ST];
	logic [RW-1:0] dv_rem_i  [DIV_ST];
	logic [QW-1:0] dv_quo_i  [DIV_ST];
	logic [RW-1:0] dv_rem_n  [DIV_ST];
	logic [QW-1:0] dv_quo_n  [DIV_ST];

	for (genvar k = 0; k < DIV_ST; k++) begin : g_div
		if (k == 0) begin : g_first
			assign dv_side_i[k] = side_s9;
			assign dv_len_i[k]  = len_s9;
			assign dv_rem_i[k]  = '0;
			assign dv_quo_i[k]  = '0;
		end else begin : g_next
			assign dv_side_i[k] = dv_side_s[k-1];
			assign dv_len_i[k]  = dv_len_s[k-1];
			assign dv_rem_i[k]  = dv_rem_s[k-1];
			assign dv_quo_i[k]  = dv_quo_s[k-1];
		end

		always_comb begin
			logic [RW:0]   r;
			logic [RW-1:0] rem;
			logic [QW-1:0] quo;
			rem = dv_rem_i[k];
			quo = dv_quo_i[k];
			r   = '0;
			for (int j = 0; j < DIV_PER; j++) begin
				if (k * DIV_PER + j < QW) begin
					// Only the top dividend bit is set.
					r = {rem, (k * DIV_PER + j == 0)};
					if (r >= {1'b0, dv_len_i[k]}) begin
						r   = r - {1'b0, dv_len_i[k]};
						quo = {quo[QW-2:0], 1'b1};
					end else begin
						quo = {quo[QW-2:0], 1'b0};
					end
					rem = r[RW-1:0];
				end
			end
			dv_rem_n[k] = rem;
			dv_quo_n[k] = quo;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[k] <= dv_side_i[k];
				dv_len_s[k]  <= dv_len_i[k];
				dv_rem_s[k]  <= dv_rem_n[k];
				dv_quo_s[k]  <= dv_quo_n[k];
			end
		end
	end

	// Square root stages: two result bits per stage.
	side_t          sq_side_s [SQ_ST];
	logic [QW-1:0]  sq_n_s    [SQ_ST];
	logic [SRW-1:0] sq_r_s    [SQ_ST];
	side_t          sq_side_i [SQ_ST];
	logic [QW-1:0]  sq_n_i    [SQ_ST];
	logic [SRW-1:0] sq_r_i    [SQ_ST];
	logic [QW-1:0]  sq_n_n    [SQ_ST];
	logic [SRW-1:0] sq_r_n    [SQ_ST];

	for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
		if (k == 0) begin : g_first
			assign sq_side_i[k] = dv_side_s[DIV_ST-1];
			assign sq_n_i[k]    = dv_quo_s[DIV_ST-1];
			assign sq_r_i[k]    = '0;
		end else begin : g_next
			assign sq_side_i[k] = sq_side_s[k-1];
			assign sq_n_i[k]    = sq_n_s[k-1];
			assign sq_r_i[k]    = sq_r_s[k-1];
		end

		always_comb begin
			logic [SRW-1:0] n;
			logic [SRW-1:0] rt;
			logic [SRW-1:0] bt;
			logic [SRW-1:0] tr;
			n  = {1'b0, sq_n_i[k]};
			rt = sq_r_i[k];
			bt = '0;
			tr = '0;
			for (int j = 0; j < SQ_PER; j++) begin
				if (k * SQ_PER + j < SQ_STEPS) begin
					bt = SRW'(1) << (2 * (SQ_STEPS - 1 - (k * SQ_PER + j)));
					tr = rt + bt;
					if (n >= tr) begin
						n  = n - tr;
						rt = (rt >> 1) + bt;
					end else begin
						rt = rt >> 1;
					end
				end
			end
			sq_n_n[k] = n[QW-1:0];
			sq_r_n[k] = rt;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_side_s[k] <= sq_side_i[k];
				sq_n_s[k]    <= sq_n_n[k];
				sq_r_s[k]    <= sq_r_n[k];
			end
		end
	end

	// Multiply stage: components times the inverse length.
	side_t                mul_side_s;
	logic signed [MW-1:0] mul_p_s [4];
	logic [IW-1:0]        inv;

	assign inv = sq_r_s[SQ_ST-1][IW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mul_p_s[i] <= $signed(sq_side_s[SQ_ST-1].c[i]) * $signed({1'b0, inv});
			end
			mul_side_s <= sq_side_s[SQ_ST-1];
		end
	end

	// Result: round and saturate the normalized components, or pass through.
	comp_t                rc [4];
	logic signed [MW-1:0] mr [4];
	logic signed [63:0]   ms [4];
	out_word_t            res_w;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mr[i] = mul_p_s[i] + $signed(MW'(1) << (FB - 1));
			ms[i] = $signed({{(64 - MW){mr[i][MW-1]}}, mr[i]}) >>> FB;
			rc[i] = mul_side_s.skip ? $signed(mul_side_s.c[i]) : sat_c(ms[i]);
		end
		res_w.blend_c0 = rc[0];
		res_w.blend_c1 = rc[1];
		res_w.blend_c2 = rc[2];
		res_w.blend_c3 = rc[3];
	end

	// Output register and skid buffer.
	out_word_t res_q;
	logic      res_v_q;
	logic      res_mode_q;
	out_word_t skid_q;
	logic      skid_mode_q;
	logic      take;
	logic      push;

	assign take = res_v_q & !blend_stall;
	assign push = en & vld_s[NPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!res_v_q || take) begin
			if (skid_v_q) begin
				res_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				res_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_v_q || take) begin
			if (skid_v_q) begin
				res_q      <= skid_q;
				res_mode_q <= skid_mode_q;
			end else begin
				res_q      <= res_w;
				res_mode_q <= mul_side_s.mode;
			end
		end else if (push) begin
			skid_q      <= res_w;
			skid_mode_q <= mul_side_s.mode;
		end
	end

	assign blend_valid = res_v_q;
	assign blend       = res_q;

	// A held skid word always has a word waiting ahead of it.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> res_v_q)
		else $error("skid word held with empty output register");

	// While the skid word is held the pipeline does not move.
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> $stable(vld_s))
		else $error("pipeline moved while skid buffer full");

	// Vector results carry a zero fourth component.
	a_vec_c3: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !res_mode_q) |-> (res_q.blend_c3 == '0))
		else $error("vector result with nonzero component 3");

	// The effective weight never exceeds one.
	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		t_eff <= ONE_W)
		else $error("effective weight above one");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Pose blend core testbench
// Drives joint words through the blend core under random idling and
// backpressure, predicts every result with an independent fixed-point
// model, and checks the results in order across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench import plnb_pkg::*; ();

	logic          clk;
	logic          arst_n;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [AW-1:0] paddr;
	logic [DW-1:0] pwdata;
	logic [DW-1:0] prdata;
	logic          pready;
	logic          pose_valid;
	logic          pose_stall;
	in_word_t      pose;
	logic          blend_valid;
	logic          blend_stall;
	out_word_t     blend;

	pose_lerp_nlerp_blend_core dut (.*);

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies used by the predictor.
	logic [WW-1:0] weight_q;
	logic [TW-1:0] tol_q;

	in_word_t  pending_words[$];
	out_word_t blend_expected[$];
	int        error_count;
	int        words_sent;
	int        words_checked;
	int        quat_words;
	bit        rx_hold;
	bit        stim_done;
	int        idle_cycles;

	localparam int IDLE_LIMIT = 20000;
	localparam int LATENCY = NPS + 10;
	localparam int HOLD_CYCLES = 200;

	// Saturate a wide value to one component.
	function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
		if (x > 128'sd2147483647) return 32'h7fffffff;
		if (x < -128'sd2147483648) return 32'h80000000;
		return x[31:0];
	endfunction

	// Round a Q32 product back to Q16 (floor after adding one half).
	function automatic logic signed [127:0] round_q(input logic signed [127:0] x);
		return (x + 128'sd32768) >>> 16;
	endfunction

	function automatic logic signed [31:0] lerp_comp(input logic signed [127:0] a,
			input logic signed [127:0] b, input logic signed [127:0] t);
		return clamp32(a + round_q((b - a) * t));
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] root;
		logic [63:0] lo;
		logic [63:0] hi;
		lo = 0;
		hi = 64'd4294967296;
		while (lo < hi) begin
			root = (lo + hi + 1) >> 1;
			if (root * root <= n) lo = root;
			else hi = root - 1;
		end
		return lo;
	endfunction

	// Expected blend word for one pose word at the current registers.
	function automatic out_word_t blend_of(input in_word_t w);
		logic signed [127:0] a[4];
		logic signed [127:0] b[4];
		logic signed [127:0] c[4];
		logic signed [127:0] t;
		logic signed [127:0] dot;
		logic [127:0]        len;
		logic [127:0]        diff;
		logic [63:0]         inv;
		out_word_t           r;
		t = (weight_q > 17'd65536) ? 128'sd65536 : 128'(weight_q);
		a[0] = w.first_c0;  a[1] = w.first_c1;  a[2] = w.first_c2;  a[3] = w.first_c3;
		b[0] = w.second_c0; b[1] = w.second_c1; b[2] = w.second_c2; b[3] = w.second_c3;
		if (!w.mode) begin
			for (int i = 0; i < 3; i++) c[i] = lerp_comp(a[i], b[i], t);
			c[3] = 0;
		end else begin
			dot = 0;
			for (int i = 0; i < 4; i++) dot += a[i] * b[i];
			if (dot < 0) begin
				for (int i = 0; i < 4; i++) b[i] = -b[i];
			end
			len = 0;
			for (int i = 0; i < 4; i++) begin
				c[i] = lerp_comp(a[i], b[i], t);
				len += (c[i] * c[i]) >> 16;
			end
			diff = (len >= 65536) ? len - 65536 : 65536 - len;
			if (len != 0 && diff > tol_q) begin
				inv = int_sqrt(64'((128'd1 << 48) / len));
				for (int i = 0; i < 4; i++) c[i] = clamp32(round_q(c[i] * $signed({64'd0, inv})));
			end
		end
		r.blend_c0 = c[0][31:0]; r.blend_c1 = c[1][31:0];
		r.blend_c2 = c[2][31:0]; r.blend_c3 = c[3][31:0];
		return r;
	endfunction

	// Word driver: random gaps, valid held until accepted.
	int tx_gap;
	always @(negedge clk) begin
		if (arst_n) begin
			if (pose_valid && !pose_stall) begin
				// Accepted at the last rising edge; handled there.
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_gap <= 0;
		end else if (pose_valid && !pose_stall) begin
			blend_expected.push_back(blend_of(pose));
			if (pose.mode) quat_words++;
			words_sent++;
			tx_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
		end else if (!pose_valid && tx_gap > 0) begin
			tx_gap <= tx_gap - 1;
		end
	end

	bit tx_taken;
	always @(posedge clk) tx_taken <= pose_valid && !pose_stall;

	always @(negedge clk) begin
		if (arst_n) begin
			if (pose_valid && !tx_taken) begin
				// Hold the stalled word.
			end else if (tx_gap == 0 && !tx_taken && pending_words.size() > 0) begin
				pose <= pending_words.pop_front();
				pose_valid <= 1'b1;
			end else if (tx_taken && tx_gap == 0 && pending_words.size() > 0 &&
					$urandom_range(0, 3) == 0) begin
				pose <= pending_words.pop_front();
				pose_valid <= 1'b1;
			end else begin
				pose_valid <= 1'b0;
			end
		end
	end

	// Result monitor and in-order checker.
	int rx_gap;
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && blend_valid && !blend_stall) begin
			if (blend_expected.size() == 0) begin
				$error("blend word with no expectation: %h", blend);
				error_count++;
			end else begin
				exp_w = blend_expected.pop_front();
				if (blend.blend_c0 !== exp_w.blend_c0) begin
					$error("blend_c0 expected %h actual %h", exp_w.blend_c0, blend.blend_c0);
					error_count++;
				end
				if (blend.blend_c1 !== exp_w.blend_c1) begin
					$error("blend_c1 expected %h actual %h", exp_w.blend_c1, blend.blend_c1);
					error_count++;
				end
				if (blend.blend_c2 !== exp_w.blend_c2) begin
					$error("blend_c2 expected %h actual %h", exp_w.blend_c2, blend.blend_c2);
					error_count++;
				end
				if (blend.blend_c3 !== exp_w.blend_c3) begin
					$error("blend_c3 expected %h actual %h", exp_w.blend_c3, blend.blend_c3);
					error_count++;
				end
			end
			words_checked++;
		end
	end

	// Receiver stall: a random wait before each word, or one long hold-off
	// whose length is counted here once it has been requested.
	bit rx_taken;
	int hold_cnt;
	always @(posedge clk) rx_taken <= blend_valid && !blend_stall;

	always @(negedge clk) begin
		if (!arst_n) begin
			rx_gap <= 0;
			hold_cnt <= 0;
		end else if (rx_hold && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			blend_stall <= 1'b1;
		end else if (rx_taken) begin
			if ($urandom_range(0, 3) == 0) begin
				rx_gap <= $urandom_range(0, 17);
				blend_stall <= 1'b1;
			end else begin
				blend_stall <= 1'b0;
			end
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			blend_stall <= 1'b1;
		end else begin
			blend_stall <= 1'b0;
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((pose_valid && !pose_stall) || (blend_valid && !blend_stall) || psel) begin
			idle_cycles <= 0;
		end else if (arst_n && !stim_done) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic reg_write(input reg_ix_t ix, input logic [DW-1:0] value);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= AW'(4 * int'(ix)); pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (ix == REG_BLEND_WEIGHT) weight_q = value[WW-1:0];
		else tol_q = value[TW-1:0];
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_words.size() > 0 || pose_valid || blend_expected.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic comp_t rand_comp(input int kind);
		case (kind)
			0: return comp_t'($urandom);
			1: return comp_t'(32'sd65536 - 32'($urandom_range(0, 131072)));
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return comp_t'($signed(32'($urandom_range(0, 4096))) - 2048);
		endcase
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		int kind;
		kind = $urandom_range(0, 9);
		kind = kind < 3 ? 0 : (kind < 8 ? 1 : (kind < 9 ? 3 : 2));
		w.mode = $urandom_range(0, 2) != 0;
		w.first_c0 = rand_comp(kind);  w.first_c1 = rand_comp(kind);
		w.first_c2 = rand_comp(kind);  w.first_c3 = rand_comp(kind);
		w.second_c0 = rand_comp(kind); w.second_c1 = rand_comp(kind);
		w.second_c2 = rand_comp(kind); w.second_c3 = rand_comp(kind);
		return w;
	endfunction

	function automatic in_word_t make_word(input logic m, input comp_t a0, input comp_t a1,
			input comp_t a2, input comp_t a3, input comp_t b0, input comp_t b1,
			input comp_t b2, input comp_t b3);
		in_word_t w;
		w.mode = m;
		w.first_c0 = a0; w.first_c1 = a1; w.first_c2 = a2; w.first_c3 = a3;
		w.second_c0 = b0; w.second_c1 = b1; w.second_c2 = b2; w.second_c3 = b3;
		return w;
	endfunction

	localparam comp_t CMAX = 32'h7fffffff;
	localparam comp_t CMIN = 32'h80000000;
	localparam comp_t ONE  = 32'sd65536;

	logic [DW-1:0] weights[6] = '{32'd0, 32'd65536, 32'd131071, 32'd32768, 32'd1, 32'd20000};
	logic [DW-1:0] tols[6] = '{32'd0, 32'd65535, 32'd1, 32'd655, 32'd0, 32'd100};

	initial begin
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		pose_valid = 0; pose = '0; blend_stall = 0;
		weight_q = '0; tol_q = 16'd1;
		error_count = 0; words_sent = 0; words_checked = 0; quat_words = 0;
		rx_hold = 0; stim_done = 0; idle_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words: field extremes, both modes, weight above one,
		// zero squared length, negative dot product, unit input.
		reg_write(REG_BLEND_WEIGHT, 32'd131071);
		reg_write(REG_UNIT_TOL, 32'd0);
		pending_words.push_back(make_word(0, CMAX, CMIN, 0, CMAX, CMIN, CMAX, -1, CMIN));
		pending_words.push_back(make_word(1, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(1, ONE, 0, 0, 0, -ONE, 0, 0, 0));
		pending_words.push_back(make_word(1, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN));
		wait_drained();
		reg_write(REG_BLEND_WEIGHT, 32'd32768);
		pending_words.push_back(make_word(0, CMAX, CMIN, 0, 5, CMIN, CMAX, -1, 7));
		pending_words.push_back(make_word(1, ONE, 0, 0, 0, 0, ONE, 0, 0));
		pending_words.push_back(make_word(1, ONE, 0, 0, 0, -ONE, 0, 0, 0));
		pending_words.push_back(make_word(1, 0, ONE, 0, 0, 0, ONE, 0, 0));
		pending_words.push_back(make_word(1, 100, 200, -300, 50, -90, -210, 280, -40));
		pending_words.push_back(make_word(1, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
		pending_words.push_back(make_word(0, -1, -1, -1, -1, 0, 0, 0, 0));
		wait_drained();

		// Random phases through several register settings.
		for (int ph = 0; ph < 6; ph++) begin
			reg_write(REG_BLEND_WEIGHT, ph == 5 ? 32'($urandom_range(0, 131071)) : weights[ph]);
			reg_write(REG_UNIT_TOL, tols[ph]);
			for (int i = 0; i < 140; i++) pending_words.push_back(rand_word());
			if (ph == 2) begin
				// Long receiver hold-off while words keep coming.
				rx_hold = 1;
			end
			wait_drained();
		end

		stim_done = 1;
		$display("Sent %0d pose words (%0d quaternion), checked %0d blend words,",
			words_sent, quat_words, words_checked);
		$display("over eight register settings including weight and tolerance extremes.");
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
